>>> sv/dual_stepper_step_generator_defines.svh
// Assertion macros shared by the checker file.
`ifndef DUAL_STEPPER_STEP_GENERATOR_DEFINES_SVH
`define DUAL_STEPPER_STEP_GENERATOR_DEFINES_SVH

// Same-cycle implication, checked outside reset.
`define DSSG_ASSERT_NOW(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("same-cycle check failed");

// Next-cycle implication, checked outside reset.
`define DSSG_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("next-cycle check failed");

`endif

>>> sv/dssg_pkg.sv
package dssg_pkg;

    // Function codes of an input item.
    typedef enum logic {
        FUNC_TICK  = 1'b0,
        FUNC_START = 1'b1
    } t_func;

    // Channel select codes.
    typedef enum logic {
        CHAN_A = 1'b0,
        CHAN_B = 1'b1
    } t_chan_sel;

    // Configuration register indexes.
    typedef enum logic [2:0] {
        CFG_DELAY_A    = 3'd0,
        CFG_DELAY_B    = 3'd1,
        CFG_STOP_POS_A = 3'd2,
        CFG_STOP_POS_B = 3'd3,
        CFG_STOP_EN_A  = 3'd4,
        CFG_STOP_EN_B  = 3'd5
    } t_cfg_reg;

    localparam int unsigned CFG_IDX_W = 3;
    localparam int unsigned CFG_DATA_W = 8;

    // The deceleration table has a fixed length; longer distances use its last entry.
    localparam logic [6:0] BRAKE_TAB_SIZE = 7'd48;
    localparam logic [5:0] BRAKE_TAB_LAST = 6'd47;

    // Per-channel state.
    typedef struct packed {
        logic [7:0] countdown;
        logic [5:0] position;
        logic [7:0] cur_delay;
        logic       index_latch;
        logic       brake_mode;
        logic       running;
    } t_chan;

    // Result of one step: new channel state and whether the indicator is cleared.
    typedef struct packed {
        t_chan ch;
        logic  rezero;
    } t_adv;

    // Deceleration table, indexed by distance to the stop target.
    function automatic logic [7:0] brake_delay(logic [5:0] idx);
        logic [7:0] d;
        case (idx) inside
            6'd0:          d = 8'd0;
            6'd1:          d = 8'd60;
            6'd2:          d = 8'd47;
            6'd3:          d = 8'd41;
            6'd4:          d = 8'd37;
            6'd5:          d = 8'd34;
            6'd6:          d = 8'd31;
            6'd7:          d = 8'd28;
            6'd8:          d = 8'd26;
            6'd9:          d = 8'd24;
            6'd10:         d = 8'd23;
            6'd11:         d = 8'd21;
            6'd12:         d = 8'd20;
            6'd13:         d = 8'd19;
            6'd14:         d = 8'd18;
            6'd15:         d = 8'd17;
            6'd16:         d = 8'd16;
            [6'd17:6'd18]: d = 8'd15;
            default:       d = 8'd14;
        endcase
        return d;
    endfunction

    // One step of a channel: advance the position, handle index re-zero and braking.
    function automatic t_adv chan_advance(t_chan s, logic [5:0] stop_pos, logic stop_en,
                                          logic [6:0] steps);
        t_adv       r;
        logic [6:0] p;
        logic [6:0] gap;
        logic [7:0] tab;
        r.ch = s;
        r.rezero = 1'b0;
        tab = 8'd0;
        p = {1'b0, s.position} + 7'd1;
        if (p >= steps) begin
            p = 7'd0;
        end
        // A latched index sensor re-zeroes the position on a quarter boundary.
        if (p[1:0] == 2'b00 && s.index_latch) begin
            r.ch.index_latch = 1'b0;
            r.rezero = 1'b1;
            p = 7'd0;
        end
        r.ch.position = p[5:0];
        if ({1'b0, stop_pos} >= p) begin
            gap = {1'b0, stop_pos} - p;
        end else begin
            gap = {1'b0, stop_pos} + steps - p;
        end
        if (stop_en) begin
            if (s.brake_mode) begin
                tab = brake_delay((gap >= BRAKE_TAB_SIZE) ? BRAKE_TAB_LAST : gap[5:0]);
                r.ch.cur_delay = tab;
                if (tab == 8'd0) begin
                    r.ch.running = 1'b0;
                    r.ch.brake_mode = 1'b0;
                end
            end else if (gap == 7'd0) begin
                r.ch.brake_mode = 1'b1;
            end
        end
        return r;
    endfunction

endpackage

>>> sv/dual_stepper_step_generator.sv
// Dual stepper step generator.
// Input channel (i_in_valid / o_in_ready) carries one item per timer tick or
// channel start: i_func selects tick or start, i_chan picks the channel to
// start, i_sensor_a/b are the index sensor levels sampled on a tick.
// Output channel (o_out_valid / i_out_ready) returns one item per input item:
// Gray phases, positions, running flags and the shared index indicator, all
// as they stand after that input item.
// Configuration channel (i_cfg_valid / o_cfg_ready) writes delay, stop target
// and stop enable registers; it is always ready and should be used only while
// the block is idle.
// Latency: the result item is valid in the cycle after its input item is
// accepted. Throughput: one item per cycle; the channel state update is a
// single combinational pass between the state registers and the result.
// When the receiver stalls, the pending result holds and the input stalls
// with it; a new item is taken in the same cycle the pending one is taken.
// Reset (synchronous) clears all channel state, registers and the result.
module dual_stepper_step_generator #(
    parameter int STEPS_PER_REV = 48
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_in_valid,
    output logic                           o_in_ready,
    input  logic                           i_func,
    input  logic                           i_chan,
    input  logic                           i_sensor_a,
    input  logic                           i_sensor_b,
    output logic                           o_out_valid,
    input  logic                           i_out_ready,
    output logic [1:0]                     o_phase_a,
    output logic [1:0]                     o_phase_b,
    output logic                           o_index_flag,
    output logic                           o_running_a,
    output logic                           o_running_b,
    output logic [5:0]                     o_position_a,
    output logic [5:0]                     o_position_b,
    input  logic                           i_cfg_valid,
    output logic                           o_cfg_ready,
    input  logic [dssg_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  logic [dssg_pkg::CFG_DATA_W-1:0] i_cfg_data
);

    localparam logic [6:0] STEPS = 7'(STEPS_PER_REV);

    logic [7:0]     r_delay_a, r_delay_b;
    logic [5:0]     r_stop_pos_a, r_stop_pos_b;
    logic           r_stop_en_a, r_stop_en_b;
    dssg_pkg::t_chan r_a, r_b, n_a, n_b;
    logic           r_ind, n_ind;
    logic           r_out_valid;
    logic           in_acc;
    logic           a_step;
    dssg_pkg::t_adv adv_a, adv_b;

    assign o_cfg_ready = 1'b1;
    assign o_in_ready = !r_out_valid || i_out_ready;
    assign in_acc = i_in_valid && o_in_ready;

    // Configuration registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_delay_a <= '0;
            r_delay_b <= '0;
            r_stop_pos_a <= '0;
            r_stop_pos_b <= '0;
            r_stop_en_a <= 1'b0;
            r_stop_en_b <= 1'b0;
        end else if (i_cfg_valid) begin
            case (dssg_pkg::t_cfg_reg'(i_cfg_index))
                dssg_pkg::CFG_DELAY_A:    r_delay_a <= i_cfg_data;
                dssg_pkg::CFG_DELAY_B:    r_delay_b <= i_cfg_data;
                dssg_pkg::CFG_STOP_POS_A: r_stop_pos_a <= i_cfg_data[5:0];
                dssg_pkg::CFG_STOP_POS_B: r_stop_pos_b <= i_cfg_data[5:0];
                dssg_pkg::CFG_STOP_EN_A:  r_stop_en_a <= i_cfg_data[0];
                dssg_pkg::CFG_STOP_EN_B:  r_stop_en_b <= i_cfg_data[0];
                default: ;
            endcase
        end
    end

    // Next channel state for one item: A is handled first, then B.
    always_comb begin
        n_a = r_a;
        n_b = r_b;
        n_ind = r_ind;
        a_step = 1'b0;
        adv_a = '0;
        adv_b = '0;
        if (in_acc) begin
            if (i_func == dssg_pkg::FUNC_START) begin
                if (i_chan == dssg_pkg::CHAN_A) begin
                    n_a.running = 1'b1;
                    n_a.cur_delay = r_delay_a;
                    n_a.countdown = r_delay_a;
                    n_a.brake_mode = 1'b0;
                end else begin
                    n_b.running = 1'b1;
                    n_b.cur_delay = r_delay_b;
                    n_b.countdown = r_delay_b;
                    n_b.brake_mode = 1'b0;
                end
            end else begin
                // Channel A tick.
                if (r_a.running) begin
                    if (r_a.position[1:0] == 2'b11 && i_sensor_a) begin
                        n_a.index_latch = 1'b1;
                        n_ind = 1'b1;
                    end
                    n_a.countdown = r_a.countdown - 8'd1;
                    if (n_a.countdown == 8'd0) begin
                        a_step = 1'b1;
                        n_a.countdown = r_a.cur_delay;
                        adv_a = dssg_pkg::chan_advance(n_a, r_stop_pos_a, r_stop_en_a, STEPS);
                        n_a = adv_a.ch;
                        if (adv_a.rezero) begin
                            n_ind = 1'b0;
                        end
                    end
                end
                // Channel B tick; its step waits a tick if A just stepped.
                if (r_b.running) begin
                    if (r_b.position[1:0] == 2'b11 && i_sensor_b) begin
                        n_b.index_latch = 1'b1;
                        n_ind = 1'b1;
                    end
                    n_b.countdown = r_b.countdown - 8'd1;
                    if (n_b.countdown == 8'd0) begin
                        if (a_step) begin
                            n_b.countdown = 8'd1;
                        end else begin
                            n_b.countdown = r_b.cur_delay;
                            adv_b = dssg_pkg::chan_advance(n_b, r_stop_pos_b, r_stop_en_b,
                                                           STEPS);
                            n_b = adv_b.ch;
                            if (adv_b.rezero) begin
                                n_ind = 1'b0;
                            end
                        end
                    end
                end
            end
        end
    end

    // State registers double as the result register; they only move on acceptance.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a <= '0;
            r_b <= '0;
            r_ind <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_a <= n_a;
            r_b <= n_b;
            r_ind <= n_ind;
            if (in_acc) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Result fields.
    assign o_out_valid = r_out_valid;
    assign o_phase_a = {r_a.position[1], r_a.position[1] ^ r_a.position[0]};
    assign o_phase_b = {r_b.position[1], r_b.position[1] ^ r_b.position[0]};
    assign o_index_flag = r_ind;
    assign o_running_a = r_a.running;
    assign o_running_b = r_b.running;
    assign o_position_a = r_a.position;
    assign o_position_b = r_b.position;

endmodule

>>> sv/dssg_checker.sv
`include "dual_stepper_step_generator_defines.svh"

module dssg_checker #(
    parameter int STEPS_PER_REV = 48
) (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       i_in_valid,
    input logic       o_in_ready,
    input logic       o_out_valid,
    input logic       i_out_ready,
    input logic [1:0] o_phase_a,
    input logic [1:0] o_phase_b,
    input logic [5:0] o_position_a,
    input logic [5:0] o_position_b
);

    localparam logic [6:0] STEPS = 7'(STEPS_PER_REV);

    // Every accepted item gives a result in the next cycle.
    `DSSG_ASSERT_NEXT(a_result_follows, i_clk, i_rst_n, i_in_valid && o_in_ready, o_out_valid)

    // A taken result with no new item leaves the output empty.
    `DSSG_ASSERT_NEXT(a_no_extra_result, i_clk, i_rst_n,
        o_out_valid && i_out_ready && !(i_in_valid && o_in_ready), !o_out_valid)

    // A stalled result keeps its positions.
    `DSSG_ASSERT_NEXT(a_stall_holds, i_clk, i_rst_n, o_out_valid && !i_out_ready,
        o_out_valid && $stable(o_position_a) && $stable(o_position_b))

    // Positions stay inside one revolution.
    `DSSG_ASSERT_NOW(a_pos_range, i_clk, i_rst_n, o_out_valid,
        {1'b0, o_position_a} < STEPS && {1'b0, o_position_b} < STEPS)

    // The phases follow the low position bits in Gray code.
    `DSSG_ASSERT_NOW(a_phase_gray, i_clk, i_rst_n, o_out_valid,
        o_phase_a == {o_position_a[1], o_position_a[1] ^ o_position_a[0]} &&
        o_phase_b == {o_position_b[1], o_position_b[1] ^ o_position_b[0]})

endmodule

bind dual_stepper_step_generator dssg_checker #(.STEPS_PER_REV(STEPS_PER_REV)) u_dssg_checker (.*);
